### hdl/rotary_position_rotate_assert.svh
// Assertion macros for the rotary position rotate block.
`ifndef ROTARY_POSITION_ROTATE_ASSERT_SVH
`define ROTARY_POSITION_ROTATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rotary_position_rotate: assertion failed");
`define RPR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("rotary_position_rotate: assertion failed");
`else
`define RPR_ASSERT(label, prop)
`define RPR_ASSERT_ALWAYS(label, prop)
`endif
`endif

### hdl/rpr_pkg.sv
package rpr_pkg;

  localparam int MaxPairs     = 128;
  localparam int DataWidth    = 16;
  localparam int CordicStages = 16;
  localparam int AtanCount    = 24;
  localparam int AngW         = 34;

  localparam int HdW   = 8;
  localparam int BaseW = 24;
  localparam int PosW  = 16;
  localparam int IdxW  = 7;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegHalfDim  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLog2Base = 1'b1;

  localparam logic [HdW-1:0]   HalfDimReset  = 8'd32;
  localparam logic [BaseW-1:0] Log2BaseReset = 24'd870817;

  localparam logic [31:0]              Ln2Q32    = 32'hB17217F8;
  localparam logic [34:0]              TwoPiQ32  = 35'd26986075409;
  localparam logic signed [AngW-1:0]   PiQ30     = 34'sd3373259426;
  localparam logic signed [AngW-1:0]   HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [AngW-1:0]   TwoPiQ30  = 34'sd6746518852;
  localparam logic signed [AngW-1:0]   GainQ30   = 34'sd652032874;

  typedef struct packed {
    logic [HdW-1:0]   half_dim;
    logic [BaseW-1:0] log2_base;
  } rpr_cfg_t;

  // Truncated arctangent of 2^-k in Q.30.
  function automatic logic signed [AngW-1:0] atan_q30(input int k);
    logic signed [AngW-1:0] v;
    case (k)
      0:  v = 34'sh3243F6A8;
      1:  v = 34'sh1DAC6705;
      2:  v = 34'sh0FADBAFC;
      3:  v = 34'sh07F56EA6;
      4:  v = 34'sh03FEAB76;
      5:  v = 34'sh01FFD55B;
      6:  v = 34'sh00FFFAAA;
      7:  v = 34'sh007FFF55;
      8:  v = 34'sh003FFFEA;
      9:  v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      default: v = 34'sh0000007F;
    endcase
    return v;
  endfunction

endpackage

### hdl/rpr_in_if.sv
interface rpr_in_if #(
  parameter int DATA_WIDTH = rpr_pkg::DataWidth
) ();
  logic                                valid;
  logic                                ready;
  logic signed [DATA_WIDTH-1:0]        first_elem;
  logic signed [DATA_WIDTH-1:0]        second_elem;
  logic        [rpr_pkg::PosW-1:0]     position;
  logic        [rpr_pkg::IdxW-1:0]     pair_index;

  modport source (output valid, first_elem, second_elem, position, pair_index, input ready);
  modport sink (input valid, first_elem, second_elem, position, pair_index, output ready);
endinterface

### hdl/rpr_out_if.sv
interface rpr_out_if #(
  parameter int DATA_WIDTH = rpr_pkg::DataWidth
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_first;
  logic signed [DATA_WIDTH-1:0] rot_second;
  logic                         saturated;

  modport source (output valid, rot_first, rot_second, saturated, input ready);
  modport sink (input valid, rot_first, rot_second, saturated, output ready);
endinterface

### hdl/rotary_position_rotate.sv
// Throughput: one beat per cycle; the input register, eight divider stages, 22 exp2 stages,
// six angle stages, a CORDIC load stage, one stage per micro-rotation and the product and
// output stages make up the pipeline, which holds as a whole while a result beat waits.
// Reset clears all valid bits and loads half_dim = 32 and log2_base = 870817.
`include "rotary_position_rotate_assert.svh"

module rotary_position_rotate #(
  parameter int DATA_WIDTH    = rpr_pkg::DataWidth,
  parameter int CORDIC_STAGES = rpr_pkg::CordicStages
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpr_pkg::BaseW-1:0]     cfg_data_i,
  rpr_in_if.sink                        in_i,
  rpr_out_if.source                     out_o
);

  localparam logic signed [DATA_WIDTH-1:0] SatMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SatMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [rpr_pkg::HdW-1:0]   hd_q;
  logic [rpr_pkg::BaseW-1:0] base_q;
  rpr_pkg::rpr_cfg_t         cfg;
  logic                      adv;
  logic                      at_rail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q   <= rpr_pkg::HalfDimReset;
      base_q <= rpr_pkg::Log2BaseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpr_pkg::RegHalfDim:  hd_q   <= cfg_data_i[rpr_pkg::HdW-1:0];
        rpr_pkg::RegLog2Base: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero pair count counts as one; counts above the pair limit are clamped.
  always_comb begin
    cfg.log2_base = base_q;
    if (hd_q == '0) begin
      cfg.half_dim = 8'd1;
    end else if (int'(hd_q) > rpr_pkg::MaxPairs) begin
      cfg.half_dim = 8'(rpr_pkg::MaxPairs);
    end else begin
      cfg.half_dim = hd_q;
    end
  end

  // The whole pipeline moves unless a result beat is held at the output.
  assign adv        = out_o.ready | ~out_o.valid;
  assign in_i.ready = adv;

  assign at_rail = (out_o.rot_first == SatMax) || (out_o.rot_first == SatMin) ||
                   (out_o.rot_second == SatMax) || (out_o.rot_second == SatMin);

  rpr_datapath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_i.valid),
    .first_elem_i  (in_i.first_elem),
    .second_elem_i (in_i.second_elem),
    .position_i    (in_i.position),
    .pair_index_i  (in_i.pair_index),
    .cfg_i         (cfg),
    .out_valid_o   (out_o.valid),
    .rot_first_o   (out_o.rot_first),
    .rot_second_o  (out_o.rot_second),
    .saturated_o   (out_o.saturated)
  );

  `RPR_ASSERT(a_sat_at_rail, out_o.valid && out_o.saturated |-> at_rail)
  `RPR_ASSERT(a_hd_range, (cfg.half_dim != 8'd0) && (int'(cfg.half_dim) <= rpr_pkg::MaxPairs))
  `RPR_ASSERT(a_hd_write, cfg_we_i && (cfg_idx_i == rpr_pkg::RegHalfDim) |=> hd_q == $past(cfg_data_i[rpr_pkg::HdW-1:0]))

endmodule

### hdl/rpr_datapath.sv
module rpr_datapath #(
  parameter int DATA_WIDTH    = rpr_pkg::DataWidth,
  parameter int CORDIC_STAGES = rpr_pkg::CordicStages
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           in_valid_i,
  input  logic signed [DATA_WIDTH-1:0]   first_elem_i,
  input  logic signed [DATA_WIDTH-1:0]   second_elem_i,
  input  logic [rpr_pkg::PosW-1:0]       position_i,
  input  logic [rpr_pkg::IdxW-1:0]       pair_index_i,
  input  rpr_pkg::rpr_cfg_t              cfg_i,
  output logic                           out_valid_o,
  output logic signed [DATA_WIDTH-1:0]   rot_first_o,
  output logic signed [DATA_WIDTH-1:0]   rot_second_o,
  output logic                           saturated_o
);

  localparam int NumCordic = (CORDIC_STAGES > rpr_pkg::AtanCount) ?
                             rpr_pkg::AtanCount : CORDIC_STAGES;
  localparam int DivSteps  = 8;
  localparam int DivBits   = 4;
  localparam int ZW        = rpr_pkg::AngW;
  localparam int MW        = DATA_WIDTH + ZW;
  localparam int PW        = DATA_WIDTH + ZW + 2;

  localparam logic [32:0] ExpOne  = 33'h1_0000_0000;
  localparam logic [19:0] RecipC  = 20'((64'd1 << 54) / rpr_pkg::TwoPiQ32);
  localparam logic signed [PW-1:0] RoundHalf = PW'(64'd1 << 29);
  localparam logic signed [PW-1:0] SatHi = PW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic [rpr_pkg::PosW-1:0]     pos;
  } elem_t;

  typedef struct packed {
    elem_t       el;
    logic [31:0] y;
    logic [5:0]  sh;
    logic        big;
  } exp_t;

  // Stage 0 and the long divider of i * log2_base by half_dim, four bits a stage.
  logic        dv_v_q   [0:DivSteps];
  logic [31:0] dv_num_q [0:DivSteps];
  logic [7:0]  dv_rem_q [0:DivSteps-1];
  logic [7:0]  dv_hd_q  [0:DivSteps-1];
  elem_t       dv_el_q  [0:DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv_i) begin
      dv_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_num_q[0]    <= {25'd0, pair_index_i} * {8'd0, cfg_i.log2_base};
      dv_rem_q[0]    <= 8'd0;
      dv_hd_q[0]     <= cfg_i.half_dim;
      dv_el_q[0].a   <= first_elem_i;
      dv_el_q[0].b   <= second_elem_i;
      dv_el_q[0].pos <= position_i;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [7:0]  rem_d;
    logic [31:0] num_d;

    always_comb begin
      logic [8:0] r9;
      rem_d = dv_rem_q[j];
      num_d = dv_num_q[j];
      r9    = '0;
      for (int b = 0; b < DivBits; b++) begin
        r9    = {rem_d, num_d[31]};
        num_d = {num_d[30:0], 1'b0};
        if (r9 >= {1'b0, dv_hd_q[j]}) begin
          rem_d    = 8'(r9 - {1'b0, dv_hd_q[j]});
          num_d[0] = 1'b1;
        end else begin
          rem_d = r9[7:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (adv_i) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_num_q[j+1] <= num_d;
        dv_el_q[j+1]  <= dv_el_q[j];
      end
    end

    if (j < DivSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          dv_rem_q[j+1] <= rem_d;
          dv_hd_q[j+1]  <= dv_hd_q[j];
        end
      end
    end
  end

  // Exponent split and f * ln2; the Horner chain starts from one.
  logic        ht_v_q [0:7];
  logic [32:0] ht_t_q [0:7];
  exp_t        ht_x_q [0:7];

  logic [30:0] e_w;
  logic [47:0] fl_w;
  assign e_w  = dv_num_q[DivSteps][30:0];
  assign fl_w = {32'd0, e_w[15:0]} * {16'd0, rpr_pkg::Ln2Q32};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ht_v_q[0] <= 1'b0;
    end else if (adv_i) begin
      ht_v_q[0] <= dv_v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ht_t_q[0]     <= ExpOne;
      ht_x_q[0].el  <= dv_el_q[DivSteps];
      ht_x_q[0].y   <= fl_w[47:16];
      ht_x_q[0].sh  <= e_w[21:16];
      ht_x_q[0].big <= (e_w[30:16] >= 15'd33);
    end
  end

  // Horner steps for exp(-y), divisor k from 7 down to 1, three stages each.
  logic        hm_v_q  [0:6];
  logic [31:0] hm_m_q  [0:6];
  exp_t        hm_x_q  [0:6];
  logic        hq_v_q  [0:6];
  logic [31:0] hq_m_q  [0:6];
  logic [31:0] hq_qa_q [0:6];
  exp_t        hq_x_q  [0:6];

  for (genvar h = 0; h < 7; h++) begin : g_horner
    localparam int K = 7 - h;
    localparam logic [35:0] Recip = 36'((64'd1 << 35) / K);

    logic [65:0] p1_w;
    logic [67:0] p2_w;
    logic [34:0] r_w;
    logic [31:0] q_w;

    assign p1_w = {34'd0, ht_x_q[h].y} * {33'd0, ht_t_q[h]};
    assign p2_w = {36'd0, hm_m_q[h]} * {32'd0, Recip};
    // The reciprocal estimate is low by at most one, fixed by one compare.
    assign r_w  = {3'd0, hq_m_q[h]} - ({3'd0, hq_qa_q[h]} * 35'(K));
    assign q_w  = hq_qa_q[h] + ((r_w >= 35'(K)) ? 32'd1 : 32'd0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hm_v_q[h]   <= 1'b0;
        hq_v_q[h]   <= 1'b0;
        ht_v_q[h+1] <= 1'b0;
      end else if (adv_i) begin
        hm_v_q[h]   <= ht_v_q[h];
        hq_v_q[h]   <= hm_v_q[h];
        ht_v_q[h+1] <= hq_v_q[h];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        hm_m_q[h]   <= p1_w[63:32];
        hm_x_q[h]   <= ht_x_q[h];
        hq_m_q[h]   <= hm_m_q[h];
        hq_qa_q[h]  <= p2_w[66:35];
        hq_x_q[h]   <= hm_x_q[h];
        ht_t_q[h+1] <= ExpOne - {1'b0, q_w};
        ht_x_q[h+1] <= hq_x_q[h];
      end
    end
  end

  // Inverse frequency, angle, reduction modulo 2*pi and folding.
  logic        iv_v_q, an_v_q, m1_v_q, m2_v_q, m3_v_q, m4_v_q;
  logic [32:0] iv_inv_q;
  elem_t       iv_el_q, an_el_q, m1_el_q, m2_el_q, m3_el_q, m4_el_q;
  logic [48:0] an_ang_q, m1_ang_q;
  logic [14:0] m1_qa_q;
  logic [35:0] m2_r_q;
  logic [32:0] m3_z_q;
  logic signed [ZW-1:0] m4_z_q;

  logic [44:0] pm_w;
  logic [49:0] qc_w;
  logic [49:0] df_w;
  logic [34:0] rr_w;
  logic signed [ZW-1:0] zs_w, zw_w, zf_w;
  logic neg_w;

  assign pm_w = {20'd0, an_ang_q[48:24]} * {25'd0, RecipC};
  assign qc_w = {35'd0, m1_qa_q} * {15'd0, rpr_pkg::TwoPiQ32};
  assign df_w = {1'b0, m1_ang_q} - qc_w;
  assign rr_w = (m2_r_q >= {1'b0, rpr_pkg::TwoPiQ32}) ?
                35'(m2_r_q - {1'b0, rpr_pkg::TwoPiQ32}) : m2_r_q[34:0];
  assign zs_w = {1'b0, m3_z_q};
  assign zw_w = (zs_w > rpr_pkg::PiQ30) ? (zs_w - rpr_pkg::TwoPiQ30) : zs_w;

  always_comb begin
    zf_w  = m4_z_q;
    neg_w = 1'b0;
    if (m4_z_q > rpr_pkg::HalfPiQ30) begin
      zf_w  = m4_z_q - rpr_pkg::PiQ30;
      neg_w = 1'b1;
    end else if (m4_z_q < -rpr_pkg::HalfPiQ30) begin
      zf_w  = m4_z_q + rpr_pkg::PiQ30;
      neg_w = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_v_q <= 1'b0;
      an_v_q <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
    end else if (adv_i) begin
      iv_v_q <= ht_v_q[7];
      an_v_q <= iv_v_q;
      m1_v_q <= an_v_q;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      iv_inv_q <= ht_x_q[7].big ? 33'd0 : (ht_t_q[7] >> ht_x_q[7].sh);
      iv_el_q  <= ht_x_q[7].el;
      an_ang_q <= {33'd0, iv_el_q.pos} * {16'd0, iv_inv_q};
      an_el_q  <= iv_el_q;
      m1_qa_q  <= pm_w[44:30];
      m1_ang_q <= an_ang_q;
      m1_el_q  <= an_el_q;
      m2_r_q   <= df_w[35:0];
      m2_el_q  <= m1_el_q;
      m3_z_q   <= rr_w[34:2];
      m3_el_q  <= m2_el_q;
      m4_z_q   <= zw_w;
      m4_el_q  <= m3_el_q;
    end
  end

  // Rotation-mode CORDIC, one micro-rotation a stage.
  logic                 cv_q  [0:NumCordic];
  logic signed [ZW-1:0] cx_q  [0:NumCordic];
  logic signed [ZW-1:0] cy_q  [0:NumCordic];
  logic signed [ZW-1:0] cz_q  [0:NumCordic-1];
  logic                 cn_q  [0:NumCordic];
  elem_t                cel_q [0:NumCordic];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv_i) begin
      cv_q[0] <= m4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cx_q[0]  <= rpr_pkg::GainQ30;
      cy_q[0]  <= '0;
      cz_q[0]  <= zf_w;
      cn_q[0]  <= neg_w;
      cel_q[0] <= m4_el_q;
    end
  end

  for (genvar k = 0; k < NumCordic; k++) begin : g_cordic
    localparam logic signed [ZW-1:0] Atan = rpr_pkg::atan_q30(k);

    logic signed [ZW-1:0] dx_w, dy_w;
    logic                 pos_w;

    assign dx_w  = cy_q[k] >>> k;
    assign dy_w  = cx_q[k] >>> k;
    assign pos_w = (cz_q[k] >= 0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cx_q[k+1]  <= pos_w ? (cx_q[k] - dx_w) : (cx_q[k] + dx_w);
        cy_q[k+1]  <= pos_w ? (cy_q[k] + dy_w) : (cy_q[k] - dy_w);
        cn_q[k+1]  <= cn_q[k];
        cel_q[k+1] <= cel_q[k];
      end
    end

    if (k < NumCordic - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          cz_q[k+1] <= pos_w ? (cz_q[k] - Atan) : (cz_q[k] + Atan);
        end
      end
    end
  end

  // Products, then sums with rounding and saturation.
  logic                 pr_v_q, pr_n_q;
  logic signed [MW-1:0] pr_ax_q, pr_by_q, pr_ay_q, pr_bx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (adv_i) begin
      pr_v_q <= cv_q[NumCordic];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pr_ax_q <= cel_q[NumCordic].a * cx_q[NumCordic];
      pr_by_q <= cel_q[NumCordic].b * cy_q[NumCordic];
      pr_ay_q <= cel_q[NumCordic].a * cy_q[NumCordic];
      pr_bx_q <= cel_q[NumCordic].b * cx_q[NumCordic];
      pr_n_q  <= cn_q[NumCordic];
    end
  end

  logic signed [PW-1:0]         s1_w, s2_w, r1_w, r2_w;
  logic signed [DATA_WIDTH-1:0] o1_w, o2_w;
  logic                         c1_w, c2_w;

  always_comb begin
    s1_w = PW'(pr_ax_q) - PW'(pr_by_q);
    s2_w = PW'(pr_ay_q) + PW'(pr_bx_q);
    // A folded angle flips the sign of both cosine and sine.
    if (pr_n_q) begin
      s1_w = -s1_w;
      s2_w = -s2_w;
    end
    r1_w = (s1_w + RoundHalf) >>> 30;
    r2_w = (s2_w + RoundHalf) >>> 30;
    c1_w = (r1_w > SatHi) || (r1_w < SatLo);
    c2_w = (r2_w > SatHi) || (r2_w < SatLo);
    if (r1_w > SatHi) begin
      o1_w = DATA_WIDTH'(SatHi);
    end else if (r1_w < SatLo) begin
      o1_w = DATA_WIDTH'(SatLo);
    end else begin
      o1_w = DATA_WIDTH'(r1_w);
    end
    if (r2_w > SatHi) begin
      o2_w = DATA_WIDTH'(SatHi);
    end else if (r2_w < SatLo) begin
      o2_w = DATA_WIDTH'(SatLo);
    end else begin
      o2_w = DATA_WIDTH'(r2_w);
    end
  end

  logic                         ov_q;
  logic signed [DATA_WIDTH-1:0] o1_q, o2_q;
  logic                         os_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv_i) begin
      ov_q <= pr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      o1_q <= o1_w;
      o2_q <= o2_w;
      os_q <= c1_w | c2_w;
    end
  end

  assign out_valid_o  = ov_q;
  assign rot_first_o  = o1_q;
  assign rot_second_o = o2_q;
  assign saturated_o  = os_q;

endmodule
